// ===== design/bia_pkg.sv =====
package bia_pkg;

    // Bitmap row width: one memory row holds this many pool positions
    localparam int ROW_BITS       = 64;
    localparam int COL_W          = 6;

    localparam int POOL_SIZE_DEF  = 2048;
    localparam logic [31:0] ID_BASE_RESET = 32'd1024;

    // Request codes
    localparam logic [1:0] REQ_ALLOC_ANY  = 2'd0;
    localparam logic [1:0] REQ_ALLOC_SPEC = 2'd1;
    localparam logic [1:0] REQ_RELEASE    = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic read;
        logic eval;
        logic commit;
    } bia_cmd_t;

endpackage

// ===== design/bia_ctrl.sv =====
module bia_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output bia_pkg::bia_cmd_t cmd
);
    import bia_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_FIND   = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:   state_next = ST_FIND;
            ST_FIND:   state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign cmd.capture = (state_reg == ST_IDLE) && start;
    assign cmd.read    = (state_reg == ST_READ);
    assign cmd.eval    = (state_reg == ST_FIND);
    assign cmd.commit  = (state_reg == ST_COMMIT);

endmodule

// ===== design/bia_dpath.sv =====
module bia_dpath #(
    parameter int POOL_SIZE = bia_pkg::POOL_SIZE_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bia_pkg::bia_cmd_t cmd,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,
    input  logic [1:0]        req_type,
    input  logic [31:0]       req_id,
    output logic              done,
    output logic [31:0]       granted_id,
    output logic              success
);
    import bia_pkg::*;

    localparam int ROWS      = (POOL_SIZE + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_IW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int POS_W     = ROW_IW + COL_W;
    localparam int LAST_BITS = POOL_SIZE - (ROWS - 1) * ROW_BITS;
    localparam logic [ROW_BITS-1:0] LAST_MASK = (LAST_BITS == ROW_BITS) ? '1 :
        ((ROW_BITS'(1) << LAST_BITS) - ROW_BITS'(1));

    // Bitmap store, one row per entry; rows never written read as all free
    logic [ROW_BITS-1:0] map_mem [ROWS];

    logic [31:0]         base_reg;
    logic [ROWS-1:0]     row_free_reg;
    logic [ROWS-1:0]     row_vld_reg;

    logic [1:0]          type_reg;
    logic [31:0]         id_reg;
    logic                in_range_reg;
    logic [POS_W-1:0]    pos_reg;

    logic [ROW_IW-1:0]   row_reg;
    logic [ROW_BITS-1:0] rd_data_reg;
    logic                rd_vld_reg;
    logic                ok_reg;

    logic [COL_W-1:0]    col_reg;
    logic [ROW_BITS-1:0] new_word_reg;
    logic                ok2_reg;

    logic                done_reg;
    logic [31:0]         granted_id_reg;
    logic                success_reg;

    logic [32:0]         diff;
    logic [ROW_IW-1:0]   ff_row;
    logic [ROW_IW-1:0]   row_sel;
    logic                ok_sel;
    logic [ROW_BITS-1:0] word;
    logic [COL_W-1:0]    ff_col;
    logic [COL_W-1:0]    col_sel;
    logic                ok_eval;
    logic [ROW_BITS-1:0] new_word;

    assign diff = {1'b0, req_id} - {1'b0, base_reg};

    // Lowest row with a free position
    always_comb
    begin
        ff_row = '0;
        for (int i = ROWS - 1; i >= 0; i--)
        begin
            if (row_free_reg[i])
            begin
                ff_row = ROW_IW'(i);
            end
        end
    end

    always_comb
    begin
        row_sel = '0;
        ok_sel  = 1'b0;
        case (type_reg)
            REQ_ALLOC_ANY:
            begin
                row_sel = ff_row;
                ok_sel  = |row_free_reg;
            end
            REQ_ALLOC_SPEC, REQ_RELEASE:
            begin
                row_sel = in_range_reg ? pos_reg[POS_W-1:COL_W] : '0;
                ok_sel  = in_range_reg;
            end
            default:
            begin
                row_sel = '0;
                ok_sel  = 1'b0;
            end
        endcase
    end

    // Effective row: unwritten rows are all free, positions past the pool are not
    assign word = (rd_vld_reg ? rd_data_reg : '1) &
                  ((row_reg == ROW_IW'(ROWS - 1)) ? LAST_MASK : '1);

    always_comb
    begin
        ff_col = '0;
        for (int b = ROW_BITS - 1; b >= 0; b--)
        begin
            if (word[b])
            begin
                ff_col = COL_W'(b);
            end
        end
    end

    always_comb
    begin
        col_sel  = pos_reg[COL_W-1:0];
        ok_eval  = ok_reg;
        new_word = word;
        case (type_reg)
            REQ_ALLOC_ANY:
            begin
                col_sel  = ff_col;
                new_word = word & ~(ROW_BITS'(1) << ff_col);
            end
            REQ_ALLOC_SPEC:
            begin
                ok_eval  = ok_reg & word[pos_reg[COL_W-1:0]];
                new_word = word & ~(ROW_BITS'(1) << pos_reg[COL_W-1:0]);
            end
            REQ_RELEASE:
            begin
                new_word = word | (ROW_BITS'(1) << pos_reg[COL_W-1:0]);
            end
            default:
            begin
                ok_eval = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= ID_BASE_RESET;
            row_free_reg <= '1;
            row_vld_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.commit;
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
            if (cmd.commit && ok2_reg)
            begin
                row_vld_reg[row_reg]  <= 1'b1;
                row_free_reg[row_reg] <= |new_word_reg;
            end
        end
    end

    // Payload pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            type_reg     <= req_type;
            id_reg       <= req_id;
            in_range_reg <= !diff[32] && (diff[31:0] < 32'(POOL_SIZE));
            pos_reg      <= diff[POS_W-1:0];
        end
        if (cmd.read)
        begin
            row_reg     <= row_sel;
            rd_data_reg <= map_mem[row_sel];
            rd_vld_reg  <= row_vld_reg[row_sel];
            ok_reg      <= ok_sel;
        end
        if (cmd.eval)
        begin
            col_reg      <= col_sel;
            new_word_reg <= new_word;
            ok2_reg      <= ok_eval;
        end
        if (cmd.commit)
        begin
            if (ok2_reg)
            begin
                map_mem[row_reg] <= new_word_reg;
            end
            success_reg <= ok2_reg;
            if (!ok2_reg)
            begin
                granted_id_reg <= '0;
            end
            else if (type_reg == REQ_ALLOC_ANY)
            begin
                granted_id_reg <= base_reg + 32'({row_reg, col_reg});
            end
            else
            begin
                granted_id_reg <= id_reg;
            end
        end
    end

    assign done       = done_reg;
    assign granted_id = granted_id_reg;
    assign success    = success_reg;

endmodule

// ===== design/bitmap_id_allocator_unit.sv =====
// Channel   Handshake            Word
// request   start, busy          req_type, req_id
// result    done (strobe)        granted_id, success
// config    cfg_we               cfg_wdata (id_base)
//
// A request passes through capture, bitmap row read, find-first and
// update, and write-back. The result strobe shows in the cycle after
// write-back, and a new request may be accepted in that same cycle.
// The single-port bitmap read-modify-write keeps requests from overlapping.
// Reset marks every row free through per-row valid bits; no clearing pass.
// The receiver cannot stall; done lasts exactly one cycle.
module bitmap_id_allocator_unit #(
    parameter int POOL_SIZE = bia_pkg::POOL_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [31:0] req_id,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    output logic        done,
    output logic [31:0] granted_id,
    output logic        success
);
    import bia_pkg::*;

    bia_cmd_t cmd;

    // Sequence each word through read, find and write-back
    bia_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    // Hold the bitmap, row summary and base; produce the result word
    bia_dpath #(
        .POOL_SIZE (POOL_SIZE)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req_type   (req_type),
        .req_id     (req_id),
        .done       (done),
        .granted_id (granted_id),
        .success    (success)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import bia_pkg::*;

    // Code that the block must ignore: it answers with a failed grant
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int POOL_SIZE   = POOL_SIZE_DEF;
    // The run is about 450 words
    localparam int CYCLE_LIMIT = 400000;
    // Cycles to let pass once the last result is in, before config or the end
    localparam int SETTLE      = 8;

    typedef struct packed {
        logic [31:0] granted_id;
        logic        success;
    } grant_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] id;
        bit          fixed;
        logic [31:0] want_id;
        logic        want_ok;
    } stim_row_t;

    // Directed words, all at the reset base of 1024. Rows with fixed set carry
    // their answer; the last few lean on the predictor.
    localparam int N_DIRECTED = 24;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{REQ_ALLOC_ANY,  32'd0,          1'b1, 32'd1024, 1'b1},
        '{REQ_ALLOC_ANY,  32'hFFFF_FFFF,  1'b1, 32'd1025, 1'b1},
        '{REQ_ALLOC_SPEC, 32'd1024,       1'b1, 32'd0,    1'b0},
        '{REQ_ALLOC_SPEC, 32'd1023,       1'b1, 32'd0,    1'b0},
        '{REQ_ALLOC_SPEC, 32'd3072,       1'b1, 32'd0,    1'b0},
        '{REQ_ALLOC_SPEC, 32'd3071,       1'b1, 32'd3071, 1'b1},
        '{REQ_ALLOC_SPEC, 32'd0,          1'b1, 32'd0,    1'b0},
        '{REQ_ALLOC_SPEC, 32'hFFFF_FFFF,  1'b1, 32'd0,    1'b0},
        '{REQ_RELEASE,    32'd1024,       1'b1, 32'd1024, 1'b1},
        '{REQ_RELEASE,    32'd1024,       1'b1, 32'd1024, 1'b1},
        '{REQ_RELEASE,    32'd3072,       1'b1, 32'd0,    1'b0},
        '{REQ_RELEASE,    32'd1023,       1'b1, 32'd0,    1'b0},
        '{REQ_RELEASE,    32'd0,          1'b1, 32'd0,    1'b0},
        '{REQ_RELEASE,    32'hFFFF_FFFF,  1'b1, 32'd0,    1'b0},
        '{REQ_UNUSED,     32'd1025,       1'b1, 32'd0,    1'b0},
        '{REQ_ALLOC_ANY,  32'd0,          1'b1, 32'd1024, 1'b1},
        '{REQ_ALLOC_ANY,  32'd0,          1'b1, 32'd1026, 1'b1},
        '{REQ_ALLOC_SPEC, 32'd1500,       1'b1, 32'd1500, 1'b1},
        '{REQ_RELEASE,    32'd1025,       1'b1, 32'd1025, 1'b1},
        '{REQ_ALLOC_ANY,  32'd0,          1'b1, 32'd1025, 1'b1},
        '{REQ_UNUSED,     32'd0,          1'b1, 32'd0,    1'b0},
        '{REQ_ALLOC_SPEC, 32'd2000,       1'b0, 32'd0,    1'b0},
        '{REQ_RELEASE,    32'd1500,       1'b0, 32'd0,    1'b0},
        '{REQ_ALLOC_SPEC, 32'd1500,       1'b0, 32'd0,    1'b0}
    };

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic [1:0]  req_type  = REQ_ALLOC_ANY;
    logic [31:0] req_id    = 32'd0;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = 32'd0;
    logic        busy;
    logic        done;
    logic [31:0] granted_id;
    logic        success;

    // Shadow of the block: free bitmap by pool position and the current base
    bit [POOL_SIZE-1:0] pool_free = '1;
    logic [31:0]        id_base_q = ID_BASE_RESET;

    grant_t pending_grants [$];

    int fail_count    = 0;
    int words_sent    = 0;
    int results_seen  = 0;
    int base_settings = 1;
    int dry_hits      = 0;
    int gap_pct       = 0;
    int cycle_count   = 0;

    bitmap_id_allocator_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .req_id     (req_id),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .done       (done),
        .granted_id (granted_id),
        .success    (success)
    );

    always #5 clk = ~clk;

    // Predict the answer to one request and advance the shadow bitmap.
    // Range test: base <= id and id - base < pool size, with no wraparound.
    function automatic grant_t predict_grant(input logic [1:0] kind, input logic [31:0] id);
        grant_t      g;
        logic [31:0] off;
        bit          hit;
        g   = '0;
        hit = 1'b0;
        off = id - id_base_q;
        case (kind)
            REQ_ALLOC_ANY:
            begin
                // Lowest free position wins
                for (int i = 0; i < POOL_SIZE; i++)
                begin
                    if (!hit && pool_free[i])
                    begin
                        pool_free[i]  = 1'b0;
                        g.granted_id  = id_base_q + i;
                        g.success     = 1'b1;
                        hit           = 1'b1;
                    end
                end
                if (!hit)
                    dry_hits++;
            end
            REQ_ALLOC_SPEC:
            begin
                // Taken or out of range: leave the bitmap alone
                if (id >= id_base_q && off < POOL_SIZE && pool_free[off])
                begin
                    pool_free[off] = 1'b0;
                    g = '{id, 1'b1};
                end
            end
            REQ_RELEASE:
            begin
                // Releasing an already free id still succeeds and echoes it
                if (id >= id_base_q && off < POOL_SIZE)
                begin
                    pool_free[off] = 1'b1;
                    g = '{id, 1'b1};
                end
            end
            default:
            begin
            end
        endcase
        return g;
    endfunction

    // Pick an id around the pool: mostly inside, biased to the low positions
    // where allocate-any lands, plus both edges and raw noise.
    function automatic logic [31:0] pick_id();
        logic [32:0] above;
        int          r;
        r     = $urandom_range(99, 0);
        above = {1'b0, id_base_q} + POOL_SIZE + $urandom_range(255, 0);
        if (r < 35)
            return id_base_q + $urandom_range(63, 0);
        if (r < 65)
            return id_base_q + $urandom_range(POOL_SIZE - 1, 0);
        if (r < 70)
            return id_base_q + POOL_SIZE - 1;
        if (r < 75)
            return id_base_q;
        if (r < 80)
            return id_base_q + POOL_SIZE;
        if (r < 85)
            return (id_base_q == 32'd0) ? 32'd0 : id_base_q - 1;
        if (r < 90)
            return above[32] ? 32'hFFFF_FFFF : above[31:0];
        return $urandom();
    endfunction

    // Present one request word and hold it until the block takes it. Called
    // just after a rising edge; returns at the edge of acceptance with start
    // still high, so a following word can go out back to back.
    task automatic send_word(input logic [1:0] kind, input logic [31:0] id,
                             input bit fixed, input grant_t want);
        grant_t g;
        if ($urandom_range(99, 0) < gap_pct)
        begin
            // Drop start for a while; long gaps outlast the busy window
            start <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
        start    <= 1'b1;
        req_type <= kind;
        req_id   <= id;
        do
            @(posedge clk);
        while (busy);
        g = predict_grant(kind, id);
        pending_grants.push_back(fixed ? want : g);
        words_sent++;
    endtask

    // Drop start and wait until every expected result is in, then settle
    task automatic drain();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (pending_grants.size() != 0 && waited < 200)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_grants.size() != 0)
        begin
            $error("%0d results never arrived", pending_grants.size());
            fail_count++;
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write id_base with the block idle; the bitmap keeps its contents
    task automatic set_base(input logic [31:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        id_base_q  = value;
        base_settings++;
        @(posedge clk);
    endtask

    // Random traffic; ignored request codes do not count toward the total
    task automatic run_random(input int count, input int release_pct);
        int         n;
        int         r;
        logic [1:0] kind;
        n = 0;
        while (n < count)
        begin
            r = $urandom_range(99, 0);
            if (r < 4)
                kind = REQ_UNUSED;
            else if (r < 4 + release_pct)
                kind = REQ_RELEASE;
            else if (r[0])
                kind = REQ_ALLOC_ANY;
            else
                kind = REQ_ALLOC_SPEC;
            send_word(kind, pick_id(), 1'b0, '0);
            if (kind != REQ_UNUSED)
                n++;
        end
    endtask

    // Compare each result word, field by field, with the oldest expectation
    always @(posedge clk)
    begin : check_results
        grant_t want;
        if (rst_n && done)
        begin
            if (pending_grants.size() == 0)
            begin
                $error("result word with no request outstanding: granted_id %0d success %0d",
                       granted_id, success);
                fail_count++;
            end
            else
            begin
                want = pending_grants.pop_front();
                if (granted_id !== want.granted_id)
                begin
                    $error("granted_id: expected %0d, got %0d", want.granted_id, granted_id);
                    fail_count++;
                end
                if (success !== want.success)
                begin
                    $error("success: expected %0d, got %0d", want.success, success);
                    fail_count++;
                end
                results_seen++;
            end
        end
    end

    // Watchdog: end a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_grants.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        stim_row_t row;
        // Hold reset low, release on a rising edge
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows at the reset base, sender idling 27 in 100
        gap_pct = 27;
        for (int k = 0; k < N_DIRECTED; k++)
        begin
            row = DIRECTED[k];
            send_word(row.kind, row.id, row.fixed, '{row.want_id, row.want_ok});
        end

        // Lowest legal base
        set_base(32'd1);
        run_random(90, 30);

        // A high base: the pool ends 2048 ids below the 32-bit top
        gap_pct = 55;
        set_base(32'hFFFF_F000);
        run_random(90, 30);

        set_base($urandom_range(32'hFFFF_F000, 1));
        run_random(70, 30);

        // No idling: a burst of allocate-any words, then a few named grants
        gap_pct = 0;
        set_base(32'h0000_0FFF);
        repeat (20) send_word(REQ_ALLOC_ANY, $urandom(), 1'b0, '0);
        repeat (3) send_word(REQ_ALLOC_SPEC, pick_id(), 1'b0, '0);
        // Lean on release to open holes again
        run_random(90, 55);

        // Back to the reset value, written explicitly
        set_base(ID_BASE_RESET);
        run_random(40, 30);

        drain();
        $display("%0d request words, %0d results checked, %0d id_base settings",
                 words_sent, results_seen, base_settings);
        $display("allocate-any found the pool exhausted %0d times", dry_hits);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
